// ===== design/rtyc_pkg.sv =====
// Shared types and constants for the RGB to YUV 4:2:0 pixel converter.
// No dependencies; compiled first.
package rtyc_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int DIM_W         = $clog2(MAX_DIMENSION + 1);
   localparam int COUNT_W       = $clog2(MAX_DIMENSION);
   localparam int CSR_DATA_W    = 13;
   localparam int PIX_W         = 8;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic even_col;
      logic is_cr;
      logic last;
   } scan_flags_type;

   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic             chroma_valid;
      logic             chroma_is_cr;
      logic [PIX_W-1:0] chroma;
      logic             frame_last;
   } pix_result_type;

   // Register value to effective dimension: 0 acts as 1, large values saturate.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIMENSION) begin
         r = DIM_W'(MAX_DIMENSION);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== design/rtyc_intf.sv =====
// Valid/ready channel interfaces for pixel items, result items and CSR writes.
// Depends on rtyc_pkg.
interface rtyc_req_if;
   import rtyc_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_red;
   logic [PIX_W-1:0] pixel_green;
   logic [PIX_W-1:0] pixel_blue;
   modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
   modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface rtyc_rsp_if;
   import rtyc_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] luma;
   logic             chroma_valid;
   logic             chroma_is_cr;
   logic [PIX_W-1:0] chroma;
   logic             frame_last;
   modport source (output valid, luma, chroma_valid, chroma_is_cr, chroma, frame_last,
                   input ready);
   modport sink   (input valid, luma, chroma_valid, chroma_is_cr, chroma, frame_last,
                   output ready);
endinterface

interface rtyc_csr_if;
   import rtyc_pkg::*;
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/rtyc_scan_ctrl.sv =====
// Frame geometry registers and column/row counters; flags per accepted item.
// Depends on rtyc_pkg and rtyc_intf.
module rtyc_scan_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   rtyc_csr_if.sink                csr_ch,
   input  logic                    step,
   output rtyc_pkg::scan_flags_type flags
);
   import rtyc_pkg::*;

   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic [COUNT_W-1:0]    col_ff, col_in;
   logic [COUNT_W-1:0]    rows_ff, rows_in;
   logic [DIM_W-1:0]      w_eff;
   logic [DIM_W-1:0]      h_eff;
   logic                  row_end;

   assign csr_ch.ready = 1'b1;

   assign w_eff   = clamp_dim(width_ff);
   assign h_eff   = clamp_dim(height_ff);
   assign row_end = ({1'b0, col_ff} + DIM_W'(1)) >= w_eff;

   always_comb begin
      flags.even_col = ~col_ff[0];
      // row index = h - 1 - rows_done
      flags.is_cr    = ~col_ff[0] & (h_eff[0] ^ rows_ff[0] ^ 1'b1);
      flags.last     = row_end & (({1'b0, rows_ff} + DIM_W'(1)) >= h_eff);
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_IMAGE_WIDTH:  width_in  = csr_ch.data;
            CSR_IMAGE_HEIGHT: height_in = csr_ch.data;
            default:          width_in  = width_ff;
         endcase
      end
      col_in  = col_ff;
      rows_in = rows_ff;
      if (step) begin
         if (row_end) begin
            col_in  = '0;
            rows_in = flags.last ? '0 : rows_ff + COUNT_W'(1);
         end else begin
            col_in  = col_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_DATA_W'(WIDTH_RESET);
         height_ff <= CSR_DATA_W'(HEIGHT_RESET);
         col_ff    <= '0;
         rows_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         rows_ff   <= rows_in;
      end
   end

endmodule

// ===== design/rtyc_csc.sv =====
// BT.601 integer color math: luma for every pixel, Cb or Cr when flagged.
// Depends on rtyc_pkg.
module rtyc_csc (
   input  logic [rtyc_pkg::PIX_W-1:0] red,
   input  logic [rtyc_pkg::PIX_W-1:0] green,
   input  logic [rtyc_pkg::PIX_W-1:0] blue,
   input  rtyc_pkg::scan_flags_type   flags,
   output rtyc_pkg::pix_result_type   result
);
   import rtyc_pkg::*;

   logic [15:0] r16, g16, b16;
   logic [15:0] luma_sum;
   logic [15:0] cb_sum;
   logic [15:0] cr_sum;

   assign r16 = {8'd0, red};
   assign g16 = {8'd0, green};
   assign b16 = {8'd0, blue};

   // Chroma sums carry +128 rounding and +32768 bias; true values stay in 0..65535.
   assign luma_sum = 16'd66 * r16 + 16'd129 * g16 + 16'd25 * b16 + 16'd128;
   assign cb_sum   = 16'd32896 + 16'd112 * b16 - 16'd38 * r16 - 16'd74 * g16;
   assign cr_sum   = 16'd32896 + 16'd112 * r16 - 16'd94 * g16 - 16'd18 * b16;

   always_comb begin
      result.luma         = luma_sum[15:8] + 8'd16;
      result.chroma_valid = flags.even_col;
      result.chroma_is_cr = flags.even_col & flags.is_cr;
      result.frame_last   = flags.last;
      if (!flags.even_col) begin
         result.chroma = '0;
      end else if (flags.is_cr) begin
         result.chroma = cr_sum[15:8];
      end else begin
         result.chroma = cb_sum[15:8];
      end
   end

endmodule

// ===== design/rgb_to_yuv420_pixel_converter.sv =====
// RGB to YUV 4:2:0 converter top level: input register, color math, result register.
// The item is held in the input register and then in the result register before rsp
// valid rises; a stall on rsp_ch.ready can hold it in either register.
// Throughput: one item per cycle unless rsp stalls; two stages with per-stage ready.
// Synchronous active-high reset clears both stage valids, the counters and loads
// the frame size registers with 1920 x 1080. Depends on rtyc_pkg, rtyc_intf,
// rtyc_scan_ctrl and rtyc_csc.
module rgb_to_yuv420_pixel_converter (
   input logic        clock,
   input logic        reset,
   rtyc_req_if.sink   req_ch,
   rtyc_rsp_if.source rsp_ch,
   rtyc_csr_if.sink   csr_ch
);
   import rtyc_pkg::*;

   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_red_ff, s1_green_ff, s1_blue_ff;
   scan_flags_type   s1_flags_ff;
   logic             out_valid_ff, out_valid_in;
   pix_result_type   out_ff;

   logic             out_ready;
   logic             s1_ready;
   logic             req_take;
   scan_flags_type   scan_flags;
   pix_result_type   s1_result;

   assign out_ready    = ~out_valid_ff | rsp_ch.ready;
   assign s1_ready     = ~s1_valid_ff | out_ready;
   assign req_ch.ready = s1_ready;
   assign req_take     = req_ch.valid & s1_ready;

   rtyc_scan_ctrl u_scan (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .step   (req_take),
      .flags  (scan_flags)
   );

   rtyc_csc u_csc (
      .red    (s1_red_ff),
      .green  (s1_green_ff),
      .blue   (s1_blue_ff),
      .flags  (s1_flags_ff),
      .result (s1_result)
   );

   always_comb begin
      s1_valid_in  = s1_ready ? req_ch.valid : s1_valid_ff;
      out_valid_in = out_ready ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_red_ff   <= req_ch.pixel_red;
         s1_green_ff <= req_ch.pixel_green;
         s1_blue_ff  <= req_ch.pixel_blue;
         s1_flags_ff <= scan_flags;
      end
      if (out_ready && s1_valid_ff) begin
         out_ff <= s1_result;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.luma         = out_ff.luma;
   assign rsp_ch.chroma_valid = out_ff.chroma_valid;
   assign rsp_ch.chroma_is_cr = out_ff.chroma_is_cr;
   assign rsp_ch.chroma       = out_ff.chroma;
   assign rsp_ch.frame_last   = out_ff.frame_last;

   a_stall_holds_s1: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_ready |=> s1_valid_ff && $stable(s1_red_ff) && $stable(s1_flags_ff))
      else $error("input stage lost an item while stalled");

   a_no_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.chroma_valid |-> out_ff.chroma == '0 && !out_ff.chroma_is_cr)
      else $error("chroma fields set without a chroma sample");

   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.luma >= 8'd16 && out_ff.luma <= 8'd235)
      else $error("luma out of range");

   a_chroma_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.chroma_valid |-> out_ff.chroma >= 8'd16 && out_ff.chroma <= 8'd240)
      else $error("chroma out of range");

   a_fill_from_s1: assert property (@(posedge clock) disable iff (reset)
      !$past(out_valid_ff) && out_valid_ff |-> $past(s1_valid_ff))
      else $error("result appeared without an item in the input stage");

endmodule
